>>> src/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted (active low).
`define PRMC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that is checked in every cycle, reset included.
`define PRMC_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/prmc_pkg.sv
// Package with the types, codes, limits and helper functions of the ramp controller.
package prmc_pkg;

    localparam int FUNC_W   = 4;
    localparam int SPEED_W  = 10;
    localparam int ANGLE_W  = 7;
    localparam int SERVO_W  = 8;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 32;

    // Function codes carried in the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_TICK       = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_SPEED  = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_BRAKE_HOLD = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_BRAKE_REL  = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_LEFT       = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_RIGHT      = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_FRONT      = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_LEFT_BY    = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_RIGHT_BY   = 4'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_TICKS = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_TICKS = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_TICKS = 4'd3;

    localparam logic [SPEED_W-1:0] SPEED_MAX  = 10'd1000;
    localparam logic [SERVO_W-1:0] SERVO_LOW  = 8'd20;
    localparam logic [SERVO_W-1:0] SERVO_HIGH = 8'd128;
    localparam logic [SERVO_W-1:0] SERVO_MID  = 8'd74;
    localparam logic [SPEED_W-1:0] PEDAL_BASE = 10'd300;

    localparam logic [SPEED_W-1:0] RST_SPEED_STEP  = 10'd20;
    localparam logic [TICKS_W-1:0] RST_SPEED_TICKS = 16'd10;
    localparam logic [TICKS_W-1:0] RST_STEER_TICKS = 16'd2;
    localparam logic [TICKS_W-1:0] RST_BRAKE_TICKS = 16'd1;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_step;
        logic [TICKS_W-1:0] speed_ticks;
        logic [TICKS_W-1:0] steer_ticks;
        logic [TICKS_W-1:0] brake_ticks;
    } t_cfg;

    typedef struct packed {
        logic               rejected;
        logic               busy_res;
        logic               brake_held;
        logic [SERVO_W-1:0] brake_duty;
        logic [SERVO_W-1:0] steer_duty;
        logic [SPEED_W-1:0] pedal_duty;
    } t_result;

    // 7*speed/10 as one multiply by 367003/2^19; exact for speeds up to 1023.
    function automatic logic [SPEED_W-1:0] pedal_duty(input logic [SPEED_W-1:0] speed);
        logic [28:0] prod;
        prod = 29'(speed) * 29'd367003;
        return PEDAL_BASE + SPEED_W'(prod[28:19]);
    endfunction

    // angle*3/5 with the divide by 5 done as a multiply by 205/1024.
    function automatic logic [SERVO_W-1:0] steer_steps(input logic [ANGLE_W-1:0] ang);
        logic [8:0]  tri_ang;
        logic [16:0] prod;
        tri_ang = 9'(ang) * 9'd3;
        prod    = 17'(tri_ang) * 17'd205;
        return SERVO_W'(prod[16:10]);
    endfunction

    function automatic logic [SPEED_W-1:0] move_speed(input logic [SPEED_W-1:0] now,
                                                      input logic [SPEED_W-1:0] goal,
                                                      input logic [SPEED_W-1:0] step);
        logic [SPEED_W-1:0] res;
        res = now;
        if (now < goal) begin
            res = ((goal - now) <= step) ? goal : now + step;
        end else if (now > goal) begin
            res = ((now - goal) <= step) ? goal : now - step;
        end
        return res;
    endfunction

    function automatic logic [SERVO_W-1:0] move_servo(input logic [SERVO_W-1:0] now,
                                                      input logic [SERVO_W-1:0] goal);
        logic [SERVO_W-1:0] res;
        res = now;
        if (now < goal) begin
            res = now + 8'd1;
        end else if (now > goal) begin
            res = now - 8'd1;
        end
        return res;
    endfunction

endpackage

>>> src/prmc_divider.sv
// Per-channel tick divider that decides when a ramp takes its next step.
module prmc_divider
    import prmc_pkg::*;
#(
    parameter int DIVIDER_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tick,
    input  logic               i_active,
    input  logic [TICKS_W-1:0] i_ticks,
    output logic               o_fire
);

    localparam int LW = (DIVIDER_WIDTH > TICKS_W) ? DIVIDER_WIDTH : TICKS_W;
    localparam logic [LW-1:0] DIV_MAX = LW'((64'd1 << DIVIDER_WIDTH) - 64'd1);

    logic [DIVIDER_WIDTH-1:0] r_count;
    logic [DIVIDER_WIDTH-1:0] n_count;
    logic [LW-1:0]            w_ticks;
    logic [LW-1:0]            w_lim;
    logic [LW-1:0]            w_cnt;
    logic [LW-1:0]            w_inc;

    always_comb begin
        w_ticks = LW'(i_ticks);
        // A zero setting acts as one, a setting past the counter range as its maximum.
        if (w_ticks == '0) begin
            w_lim = LW'(1);
        end else if (w_ticks > DIV_MAX) begin
            w_lim = DIV_MAX;
        end else begin
            w_lim = w_ticks;
        end
        w_cnt  = LW'(r_count);
        w_inc  = (w_cnt < DIV_MAX) ? w_cnt + LW'(1) : w_cnt;
        o_fire = i_tick && i_active && (w_inc >= w_lim);
        n_count = r_count;
        if (i_tick) begin
            if (!i_active || o_fire) begin
                n_count = '0;
            end else begin
                n_count = w_inc[DIVIDER_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

>>> src/prmc_core.sv
// Channel state, command handling and ramp stepping for one word per cycle while i_adv is high.
module prmc_core
    import prmc_pkg::*;
#(
    parameter int DIVIDER_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic [FUNC_W-1:0]  i_func,
    input  logic [SPEED_W-1:0] i_speed_target,
    input  logic [ANGLE_W-1:0] i_angle,
    input  t_cfg               i_cfg,
    output t_result            o_result
);

    logic [SPEED_W-1:0] r_speed_now, r_speed_goal, n_speed_now, n_speed_goal;
    logic [SERVO_W-1:0] r_steer_now, r_steer_goal, n_steer_now, n_steer_goal;
    logic [SERVO_W-1:0] r_brake_now, r_brake_goal, n_brake_now, n_brake_goal;
    logic               r_brake_flag, n_brake_flag;

    logic               w_tick;
    logic               w_busy;
    logic               w_cmd;
    logic               w_rej;
    logic               w_fire_speed, w_fire_steer, w_fire_brake;
    logic [SPEED_W-1:0] w_step;
    logic [SERVO_W-1:0] w_steps;
    logic [SERVO_W:0]   w_left_sum;
    logic [SERVO_W:0]   w_right_floor;

    assign w_tick = i_adv && (i_func == FUNC_TICK);
    assign w_busy = (r_speed_now != r_speed_goal) || (r_steer_now != r_steer_goal) ||
                    (r_brake_now != r_brake_goal);

    prmc_divider #(.DIVIDER_WIDTH(DIVIDER_WIDTH)) u_div_speed (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_tick),
        .i_active (r_speed_now != r_speed_goal),
        .i_ticks  (i_cfg.speed_ticks),
        .o_fire   (w_fire_speed)
    );

    prmc_divider #(.DIVIDER_WIDTH(DIVIDER_WIDTH)) u_div_steer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_tick),
        .i_active (r_steer_now != r_steer_goal),
        .i_ticks  (i_cfg.steer_ticks),
        .o_fire   (w_fire_steer)
    );

    prmc_divider #(.DIVIDER_WIDTH(DIVIDER_WIDTH)) u_div_brake (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (w_tick),
        .i_active (r_brake_now != r_brake_goal),
        .i_ticks  (i_cfg.brake_ticks),
        .o_fire   (w_fire_brake)
    );

    always_comb begin
        n_speed_now   = r_speed_now;
        n_speed_goal  = r_speed_goal;
        n_steer_now   = r_steer_now;
        n_steer_goal  = r_steer_goal;
        n_brake_now   = r_brake_now;
        n_brake_goal  = r_brake_goal;
        n_brake_flag  = r_brake_flag;
        w_rej         = 1'b0;
        w_step        = (i_cfg.speed_step == '0) ? SPEED_W'(1) : i_cfg.speed_step;
        w_steps       = steer_steps(i_angle);
        w_left_sum    = {1'b0, r_steer_now} + {1'b0, w_steps};
        w_right_floor = {1'b0, SERVO_LOW} + {1'b0, w_steps};
        w_cmd         = (i_func != FUNC_TICK) && (i_func <= FUNC_RIGHT_BY);

        if (i_func == FUNC_TICK) begin
            if (w_fire_speed) begin
                n_speed_now = move_speed(r_speed_now, r_speed_goal, w_step);
            end
            if (w_fire_steer) begin
                n_steer_now = move_servo(r_steer_now, r_steer_goal);
            end
            if (w_fire_brake) begin
                n_brake_now = move_servo(r_brake_now, r_brake_goal);
            end
        end else if (w_cmd && w_busy) begin
            w_rej = 1'b1;
        end else begin
            unique case (i_func)
                FUNC_SET_SPEED: begin
                    n_speed_goal = (i_speed_target > SPEED_MAX) ? SPEED_MAX : i_speed_target;
                end
                FUNC_BRAKE_HOLD: begin
                    // Holding starts from the released end and ramps toward full brake.
                    if (!r_brake_flag) begin
                        n_brake_now  = SERVO_HIGH;
                        n_brake_goal = SERVO_LOW;
                        n_brake_flag = 1'b1;
                    end
                end
                FUNC_BRAKE_REL: begin
                    if (r_brake_flag) begin
                        n_brake_now  = SERVO_LOW;
                        n_brake_goal = SERVO_HIGH;
                        n_brake_flag = 1'b0;
                    end
                end
                FUNC_LEFT:  n_steer_goal = SERVO_HIGH;
                FUNC_RIGHT: n_steer_goal = SERVO_LOW;
                FUNC_FRONT: n_steer_goal = SERVO_MID;
                FUNC_LEFT_BY: begin
                    n_steer_goal = (w_left_sum > {1'b0, SERVO_HIGH}) ?
                                   SERVO_HIGH : w_left_sum[SERVO_W-1:0];
                end
                FUNC_RIGHT_BY: begin
                    n_steer_goal = ({1'b0, r_steer_now} < w_right_floor) ?
                                   SERVO_LOW : r_steer_now - w_steps;
                end
                default: begin
                end
            endcase
        end

        o_result.pedal_duty = pedal_duty(n_speed_now);
        o_result.steer_duty = n_steer_now;
        o_result.brake_duty = n_brake_now;
        o_result.brake_held = n_brake_flag;
        o_result.busy_res   = (n_speed_now != n_speed_goal) || (n_steer_now != n_steer_goal) ||
                              (n_brake_now != n_brake_goal);
        o_result.rejected   = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_now  <= '0;
            r_speed_goal <= '0;
            r_steer_now  <= SERVO_MID;
            r_steer_goal <= SERVO_MID;
            r_brake_now  <= SERVO_HIGH;
            r_brake_goal <= SERVO_HIGH;
            r_brake_flag <= 1'b0;
        end else if (i_adv) begin
            r_speed_now  <= n_speed_now;
            r_speed_goal <= n_speed_goal;
            r_steer_now  <= n_steer_now;
            r_steer_goal <= n_steer_goal;
            r_brake_now  <= n_brake_now;
            r_brake_goal <= n_brake_goal;
            r_brake_flag <= n_brake_flag;
        end
    end

endmodule

>>> src/pwm_ramp_motion_controller.sv
// Top level of the slew-limited pedal, steering and brake PWM ramp controller.
//
//   channel  direction  handshake               payload
//   s_axis   in         s_axis_tvalid/tready    tuser: func; tdata: speed_target, angle
//   m_axis   out        m_axis_tvalid/tready    tdata: duties and status flags
//   cfg      in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// One word is accepted per cycle while s_axis_tready is high; it passes the input register and
// then the result register to m_axis, with the channel state updated as it enters the latter.
// Synchronous active-low reset clears the channel state, the dividers and the valid flags.
// A stalled output holds its word and stops the input register, so s_axis_tready falls
// only while both registers are full and m_axis_tready is low.
module pwm_ramp_motion_controller
    import prmc_pkg::*;
#(
    parameter int DIVIDER_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // speed_target[9:0], angle[16:10], zero pad
    input  logic [FUNC_W-1:0]     s_axis_tuser,  // func[3:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pedal_duty[9:0], steer_duty[17:10], brake_duty[25:18], brake_held[26],
    // busy_res[27], rejected[28], zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic [FUNC_W-1:0]  r_func;
    logic [SPEED_W-1:0] r_speed_target;
    logic [ANGLE_W-1:0] r_angle;
    logic               r_out_valid;
    t_result            r_out;
    t_result            w_result;
    logic               w_adv;

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_step  <= RST_SPEED_STEP;
            r_cfg.speed_ticks <= RST_SPEED_TICKS;
            r_cfg.steer_ticks <= RST_STEER_TICKS;
            r_cfg.brake_ticks <= RST_BRAKE_TICKS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPEED_STEP:  r_cfg.speed_step  <= i_cfg_data[SPEED_W-1:0];
                CFG_SPEED_TICKS: r_cfg.speed_ticks <= i_cfg_data;
                CFG_STEER_TICKS: r_cfg.steer_ticks <= i_cfg_data;
                CFG_BRAKE_TICKS: r_cfg.brake_ticks <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_func         <= s_axis_tuser;
            r_speed_target <= s_axis_tdata[SPEED_W-1:0];
            r_angle        <= s_axis_tdata[SPEED_W+ANGLE_W-1:SPEED_W];
        end
    end

    prmc_core #(.DIVIDER_WIDTH(DIVIDER_WIDTH)) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_func         (r_func),
        .i_speed_target (r_speed_target),
        .i_angle        (r_angle),
        .i_cfg          (r_cfg),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

endmodule

>>> src/prmc_checker.sv
// Port-level checker for the ramp controller and its bind to the top level.
`include "assert_macros.svh"

module prmc_checker
    import prmc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    t_result w_res;
    logic    w_stall;
    logic    w_in_range;
    logic    w_brake_end;

    assign w_res       = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
    assign w_stall     = m_axis_tvalid && !m_axis_tready;
    assign w_in_range  = (w_res.pedal_duty >= PEDAL_BASE) && (w_res.pedal_duty <= SPEED_MAX) &&
                         (w_res.steer_duty >= SERVO_LOW) && (w_res.steer_duty <= SERVO_HIGH) &&
                         (w_res.brake_duty >= SERVO_LOW) && (w_res.brake_duty <= SERVO_HIGH);
    assign w_brake_end = w_res.brake_held ? (w_res.brake_duty == SERVO_LOW) :
                                            (w_res.brake_duty == SERVO_HIGH);

    // A stalled result word stays on the bus unchanged.
    `PRMC_ASSERT_RST(a_out_hold, i_clk, i_rst_n,
                     w_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled word changed")

    `PRMC_ASSERT_RST(a_duty_range, i_clk, i_rst_n, m_axis_tvalid |-> w_in_range, "duty out of range")

    // A dropped command leaves the ramp that caused it still running.
    `PRMC_ASSERT_RST(a_rej_busy, i_clk, i_rst_n,
                     m_axis_tvalid && w_res.rejected |-> w_res.busy_res, "rejected while idle")

    // At rest the brake sits at the end that matches its held state.
    `PRMC_ASSERT_RST(a_brake_rest, i_clk, i_rst_n,
                     m_axis_tvalid && !w_res.busy_res |-> w_brake_end, "brake at rest off its end")

    `PRMC_ASSERT_ALL(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind pwm_ramp_motion_controller prmc_checker u_prmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
